### hw/rtl/hwt_pkg.sv
// ----------------------------------------------------------------------------
// hwt_pkg
// Shared types and codes of the hierarchical timer wheel.
// ----------------------------------------------------------------------------
package hwt_pkg;

    localparam int ID_FIELD_W = 6;
    localparam int DL_W       = 32;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EXPIRED = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NONE    = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UNL_RD,
        ST_UNL_WR,
        ST_PLC_CALC,
        ST_PLC_WR,
        ST_RESP,
        ST_CAS_RD,
        ST_CAS_HEAD,
        ST_CAS_NXT,
        ST_CAS_GET,
        ST_CAS_ADV,
        ST_CAS_END,
        ST_EXP_RD,
        ST_EXP_HEAD
    } state_t;

endpackage

### hw/rtl/hierarchical_timer_wheel_top.sv
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_top
// Cascading timer wheel with per-slot FIFO lists kept in on-chip memories.
// ----------------------------------------------------------------------------
// Input beats on s_*: tuser carries the command kind (add, remove, modify,
// tick), tdata the timer id and the absolute deadline. Result beats on m_*:
// tuser carries the status, tdata the expired timer id, tlast marks the final
// result of a command. Add, remove and modify give one beat; a tick gives one
// beat per expired timer, or a single "nothing expired" beat.
// One sequencer drives all list memories. An add places the timer, a remove
// unlinks it, a modify unlinks and then places it; a tick unlinks each expired
// timer and, on a level-0 wrap, first runs a cascade that re-places the timers
// of each level visited.
// s_tready is high only while the sequencer is idle. Results go through an
// output register; while m_tready is low the sequencer holds at the next
// result and takes no new beat.
// After reset the slot head memory is cleared one entry per cycle, all
// LEVELS * 2^SLOT_BITS entries (1024 by default); s_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_top
    import hwt_pkg::*;
#(
    parameter int NUM_TIMERS = 64,
    parameter int LEVELS     = 4,
    parameter int SLOT_BITS  = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // timer_id[5:0], deadline[37:6], zero
    input  logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // expired_id[5:0], zero
    output logic [STATUS_W-1:0]   m_tuser,   // status[1:0]
    output logic                  m_tlast
);

    localparam int ID_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int SLOT_AW   = LVL_W + SLOT_BITS;
    localparam int NUM_SLOTS = LEVELS * (1 << SLOT_BITS);
    localparam logic [ID_W:0] NIL = {1'b1, {ID_W{1'b0}}};

    state_t state_reg, state_next;

    logic [KIND_W-1:0]   op_reg, op_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [DL_W-1:0]     dl_reg, dl_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ID_W:0]       nx_reg, nx_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [ID_W-1:0]     emit_id_reg, emit_id_next;
    logic                emit_vld_reg, emit_vld_next;
    logic [DL_W-1:0]     time_reg, time_next;
    logic [SLOT_BITS-1:0] cursor_reg [LEVELS];
    logic [SLOT_BITS-1:0] cursor_next [LEVELS];
    logic [NUM_TIMERS-1:0] pending_reg, pending_next;
    logic [SLOT_AW-1:0]  clr_cnt_reg, clr_cnt_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [ID_FIELD_W-1:0] m_id_reg, m_id_next;
    logic                  m_last_reg, m_last_next;

    logic [ID_W:0]        head_mem [NUM_SLOTS];
    logic [ID_W-1:0]      tail_mem [NUM_SLOTS];
    logic [ID_W:0]        next_mem [NUM_TIMERS];
    logic [ID_W:0]        prev_mem [NUM_TIMERS];
    logic [SLOT_AW-1:0]   eslot_mem [NUM_TIMERS];
    logic [DL_W-1:0]      dl_mem [NUM_TIMERS];

    logic [ID_W:0]        head_rd_reg, next_rd_reg, prev_rd_reg;
    logic [ID_W-1:0]      tail_rd_reg;
    logic [SLOT_AW-1:0]   eslot_rd_reg;
    logic [DL_W-1:0]      dl_rd_reg;

    logic                 head_we, tail_we, next_we, prev_we, eslot_we, dl_we;
    logic [SLOT_AW-1:0]   head_waddr, tail_waddr, head_raddr;
    logic [ID_W:0]        head_wdata, next_wdata, prev_wdata;
    logic [ID_W-1:0]      tail_wdata, next_waddr, prev_waddr;

    logic                  in_acc, in_ok, in_pend, out_free, cas_more;
    logic [ID_FIELD_W-1:0] in_id;
    logic [KIND_W-1:0]     in_kind;
    logic [DL_W-1:0]       in_dl, interval;
    logic [SLOT_AW-1:0]    plc_slot;
    logic                  plc_found;

    assign in_kind  = s_tuser;
    assign in_id    = s_tdata[ID_FIELD_W-1:0];
    assign in_dl    = s_tdata[ID_FIELD_W +: DL_W];
    assign in_acc   = s_tvalid && s_tready;
    assign in_ok    = {1'b0, in_id} < (ID_FIELD_W+1)'(NUM_TIMERS);
    assign in_pend  = pending_reg[in_id[ID_W-1:0]];
    assign out_free = !m_tvalid_reg || m_tready;
    assign cas_more = (cursor_reg[lvl_reg] == '0) && (lvl_reg != LVL_W'(LEVELS - 1));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = M_TDATA_W'(m_id_reg);
    assign m_tlast  = m_last_reg;

    // slot selection by distance from current time
    assign interval = dl_reg - time_reg;
    always_comb begin
        plc_slot  = {{LVL_W{1'b0}}, cursor_reg[0]};
        plc_found = 1'b0;
        for (int l = 0; l < LEVELS - 1; l++) begin
            if (!plc_found && ((interval >> (SLOT_BITS * (l + 1))) == '0)) begin
                plc_slot  = {LVL_W'(l), dl_reg[SLOT_BITS*l +: SLOT_BITS]};
                plc_found = 1'b1;
            end
        end
        if (!plc_found && !interval[DL_W-1]) begin
            plc_slot = {LVL_W'(LEVELS - 1), dl_reg[SLOT_BITS*(LEVELS-1) +: SLOT_BITS]};
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == SLOT_AW'(NUM_SLOTS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_kind == KIND_TICK) begin
                        state_next = (cursor_reg[0] == '0) ? ST_CAS_RD : ST_EXP_RD;
                    end else if (!in_ok) begin
                        state_next = ST_RESP;
                    end else if (in_kind == KIND_ADD) begin
                        state_next = in_pend ? ST_RESP : ST_PLC_CALC;
                    end else if (in_kind == KIND_REMOVE) begin
                        state_next = in_pend ? ST_UNL_RD : ST_RESP;
                    end else begin
                        state_next = in_pend ? ST_UNL_RD : ST_PLC_CALC;
                    end
                end
            end
            ST_UNL_RD: state_next = ST_UNL_WR;
            ST_UNL_WR: begin
                if (op_reg == KIND_TICK)        state_next = ST_EXP_RD;
                else if (op_reg == KIND_MODIFY) state_next = ST_PLC_CALC;
                else                            state_next = ST_RESP;
            end
            ST_PLC_CALC: state_next = ST_PLC_WR;
            ST_PLC_WR: state_next = (op_reg == KIND_TICK) ? ST_CAS_ADV : ST_RESP;
            ST_RESP: begin
                if (out_free) state_next = ST_IDLE;
            end
            ST_CAS_RD: state_next = ST_CAS_HEAD;
            ST_CAS_HEAD: state_next = head_rd_reg[ID_W] ? ST_CAS_END : ST_CAS_NXT;
            ST_CAS_NXT: state_next = ST_CAS_GET;
            ST_CAS_GET: state_next = ST_PLC_CALC;
            ST_CAS_ADV: state_next = nx_reg[ID_W] ? ST_CAS_END : ST_CAS_NXT;
            ST_CAS_END: state_next = cas_more ? ST_CAS_RD : ST_EXP_RD;
            ST_EXP_RD: state_next = ST_EXP_HEAD;
            ST_EXP_HEAD: begin
                if (head_rd_reg[ID_W]) begin
                    if (out_free) state_next = ST_IDLE;
                end else if (out_free || !emit_vld_reg) begin
                    state_next = ST_UNL_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        op_next       = op_reg;
        id_next       = id_reg;
        dl_next       = dl_reg;
        status_next   = status_reg;
        nx_next       = nx_reg;
        lvl_next      = lvl_reg;
        emit_id_next  = emit_id_reg;
        emit_vld_next = emit_vld_reg;
        time_next     = time_reg;
        cursor_next   = cursor_reg;
        pending_next  = pending_reg;
        clr_cnt_next  = clr_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_id_next     = m_id_reg;
        m_last_next   = m_last_reg;

        head_we = 1'b0; head_waddr = plc_slot; head_wdata = NIL;
        tail_we = 1'b0; tail_waddr = plc_slot; tail_wdata = id_reg;
        next_we = 1'b0; next_waddr = id_reg;   next_wdata = NIL;
        prev_we = 1'b0; prev_waddr = id_reg;   prev_wdata = NIL;
        eslot_we = 1'b0;
        dl_we   = 1'b0;
        head_raddr = {{LVL_W{1'b0}}, cursor_reg[0]};

        case (state_reg)
            ST_CLEAR: begin
                head_we      = 1'b1;
                head_waddr   = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE: begin
                if (in_acc) begin
                    op_next       = in_kind;
                    id_next       = in_id[ID_W-1:0];
                    dl_next       = in_dl;
                    emit_vld_next = 1'b0;
                    lvl_next      = LVL_W'(1);
                    status_next   = (in_kind == KIND_ADD && in_ok && in_pend) ?
                                    STAT_REFUSED : STAT_DONE;
                    dl_we = in_ok && ((in_kind == KIND_ADD && !in_pend) ||
                                      in_kind == KIND_MODIFY);
                end
            end
            ST_UNL_WR: begin
                pending_next[id_reg] = 1'b0;
                head_waddr = eslot_rd_reg;
                tail_waddr = eslot_rd_reg;
                head_wdata = next_rd_reg;
                head_we    = prev_rd_reg[ID_W];
                next_waddr = prev_rd_reg[ID_W-1:0];
                next_wdata = next_rd_reg;
                next_we    = !prev_rd_reg[ID_W];
                prev_waddr = next_rd_reg[ID_W-1:0];
                prev_wdata = prev_rd_reg;
                prev_we    = !next_rd_reg[ID_W];
                tail_wdata = prev_rd_reg[ID_W-1:0];
                tail_we    = next_rd_reg[ID_W] && !prev_rd_reg[ID_W];
            end
            ST_PLC_CALC: begin
                head_raddr = plc_slot;
                pending_next[id_reg] = 1'b1;
                next_we  = 1'b1;
                eslot_we = 1'b1;
            end
            ST_PLC_WR: begin
                tail_we = 1'b1;
                prev_we = 1'b1;
                if (head_rd_reg[ID_W]) begin
                    head_we    = 1'b1;
                    head_wdata = {1'b0, id_reg};
                end else begin
                    prev_wdata = {1'b0, tail_rd_reg};
                    next_we    = 1'b1;
                    next_waddr = tail_rd_reg;
                    next_wdata = {1'b0, id_reg};
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    m_id_next     = '0;
                    m_last_next   = 1'b1;
                end
            end
            ST_CAS_RD: begin
                head_raddr = {lvl_reg, cursor_reg[lvl_reg]};
            end
            ST_CAS_HEAD: begin
                head_we    = 1'b1;
                head_waddr = {lvl_reg, cursor_reg[lvl_reg]};
                id_next    = head_rd_reg[ID_W-1:0];
            end
            ST_CAS_GET: begin
                nx_next = next_rd_reg;
                dl_next = dl_rd_reg;
            end
            ST_CAS_ADV: begin
                id_next = nx_reg[ID_W-1:0];
            end
            ST_CAS_END: begin
                cursor_next[lvl_reg] = cursor_reg[lvl_reg] + 1'b1;
                if (cas_more) lvl_next = lvl_reg + 1'b1;
            end
            ST_EXP_HEAD: begin
                if (head_rd_reg[ID_W]) begin
                    if (out_free) begin
                        m_tvalid_next  = 1'b1;
                        m_status_next  = emit_vld_reg ? STAT_EXPIRED : STAT_NONE;
                        m_id_next      = emit_vld_reg ? ID_FIELD_W'(emit_id_reg) : '0;
                        m_last_next    = 1'b1;
                        time_next      = time_reg + 1'b1;
                        cursor_next[0] = cursor_reg[0] + 1'b1;
                    end
                end else if (out_free || !emit_vld_reg) begin
                    if (emit_vld_reg) begin
                        m_tvalid_next = 1'b1;
                        m_status_next = STAT_EXPIRED;
                        m_id_next     = ID_FIELD_W'(emit_id_reg);
                        m_last_next   = 1'b0;
                    end
                    emit_vld_next = 1'b1;
                    emit_id_next  = head_rd_reg[ID_W-1:0];
                    id_next       = head_rd_reg[ID_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (head_we)  head_mem[head_waddr] <= head_wdata;
        if (tail_we)  tail_mem[tail_waddr] <= tail_wdata;
        if (next_we)  next_mem[next_waddr] <= next_wdata;
        if (prev_we)  prev_mem[prev_waddr] <= prev_wdata;
        if (eslot_we) eslot_mem[id_reg] <= plc_slot;
        if (dl_we)    dl_mem[in_id[ID_W-1:0]] <= in_dl;
        head_rd_reg  <= head_mem[head_raddr];
        tail_rd_reg  <= tail_mem[plc_slot];
        next_rd_reg  <= next_mem[id_reg];
        prev_rd_reg  <= prev_mem[id_reg];
        eslot_rd_reg <= eslot_mem[id_reg];
        dl_rd_reg    <= dl_mem[id_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            time_reg     <= '0;
            pending_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            emit_vld_reg <= 1'b0;
            lvl_reg      <= '0;
            for (int i = 0; i < LEVELS; i++) cursor_reg[i] <= '0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            time_reg     <= time_next;
            pending_reg  <= pending_next;
            m_tvalid_reg <= m_tvalid_next;
            emit_vld_reg <= emit_vld_next;
            lvl_reg      <= lvl_next;
            cursor_reg   <= cursor_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        dl_reg       <= dl_next;
        status_reg   <= status_next;
        nx_reg       <= nx_next;
        emit_id_reg  <= emit_id_next;
        m_status_reg <= m_status_next;
        m_id_reg     <= m_id_next;
        m_last_reg   <= m_last_next;
    end

endmodule

### hw/rtl/hwt_checker.sv
// ----------------------------------------------------------------------------
// hwt_checker
// Port-level checks of the timer wheel result channel and of input acceptance.
// ----------------------------------------------------------------------------
module hwt_checker
    import hwt_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [KIND_W-1:0]    s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser,
    input logic                 m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_DONE || m_tuser == STAT_REFUSED ||
                     m_tuser == STAT_NONE) |-> m_tlast)
        else $error("single-beat result without tlast");

    a_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_EXPIRED |-> m_tdata == '0)
        else $error("nonzero id on non-expiry result");

    a_no_take_mid_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |-> !s_tready)
        else $error("input taken before tick results finished");

endmodule

bind hierarchical_timer_wheel_top hwt_checker u_hwt_checker (.*);
